>>> src/forgiving_base64_decoder_unit_assert.svh
// Assertion macros for the base64 decoder unit.
// Each macro expects clk and rst_n in scope.
`ifndef FORGIVING_BASE64_DECODER_UNIT_ASSERT_SVH
`define FORGIVING_BASE64_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define B64D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_OK         = 2'd1,
        KIND_BAD_LENGTH = 2'd2,
        KIND_BAD_CHAR   = 2'd3
    } item_kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        item_kind_t kind;
        logic       eom;
    } result_t;

    // Up to two results pushed per processed character
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Character codes
    localparam logic [7:0] CH_PAD    = 8'h3D; // '='
    localparam logic [7:0] CH_DASH   = 8'h2D; // '-'
    localparam logic [7:0] CH_USCORE = 8'h5F; // '_'
    localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
    localparam logic [7:0] CH_SLASH  = 8'h2F; // '/'
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;

    // Offsets from character code to sextet
    localparam logic [7:0] OFS_UPPER = 8'h41; // 'A' -> 0
    localparam logic [7:0] OFS_LOWER = 8'h47; // 'a' -> 26
    localparam logic [7:0] OFS_DIGIT = 8'h04; // '0' -> 52 (added)
    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    localparam int FIFO_DEPTH = 4;

endpackage

`default_nettype wire

>>> src/b64d_sextet_dec.sv
`default_nettype none

// Character to sextet lookup, both alphabets.
module b64d_sextet_dec (
    input  wire logic [7:0] in_char,
    output logic      [5:0] sextet,
    output logic            in_alphabet
);

    logic [7:0] diff;

    always_comb
    begin
        diff        = 8'h00;
        sextet      = 6'd0;
        in_alphabet = 1'b1;
        unique case (in_char) inside
            [b64d_pkg::CH_UP_A : b64d_pkg::CH_UP_Z]:
            begin
                diff   = in_char - b64d_pkg::OFS_UPPER;
                sextet = diff[5:0];
            end
            [b64d_pkg::CH_LO_A : b64d_pkg::CH_LO_Z]:
            begin
                diff   = in_char - b64d_pkg::OFS_LOWER;
                sextet = diff[5:0];
            end
            [b64d_pkg::CH_DIG_0 : b64d_pkg::CH_DIG_9]:
            begin
                diff   = in_char + b64d_pkg::OFS_DIGIT;
                sextet = diff[5:0];
            end
            b64d_pkg::CH_PLUS, b64d_pkg::CH_DASH:
            begin
                sextet = b64d_pkg::SEXTET_62;
            end
            b64d_pkg::CH_SLASH, b64d_pkg::CH_USCORE:
            begin
                sextet = b64d_pkg::SEXTET_63;
            end
            default:
            begin
                in_alphabet = 1'b0; // kept, decodes as zero
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/b64d_core.sv
`default_nettype none

// Input register, group state and shift-merge of sextets.
module b64d_core #(
    parameter  int DEPTH = b64d_pkg::FIFO_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,
    input  wire logic          s_axis_tlast,
    input  wire logic [CW-1:0] fifo_free,
    output b64d_pkg::push_t    push
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    logic [1:0] pos_reg, pos_next;
    logic [5:0] prior_reg, prior_next;
    logic       bad_reg, bad_next;

    logic [5:0] sextet;
    logic       sextet_ok;

    logic                 kept;
    logic                 has_data;
    logic [1:0]           pos_adv;
    logic                 bad_adv;
    logic [7:0]           data_byte;
    logic [1:0]           push_n;
    logic                 fire;
    b64d_pkg::item_kind_t end_kind;
    b64d_pkg::result_t    data_item;
    b64d_pkg::result_t    end_item;

    b64d_sextet_dec u_dec (
        .in_char     (in_char_reg),
        .sextet      (sextet),
        .in_alphabet (sextet_ok)
    );

    always_comb
    begin
        kept     = (in_char_reg != b64d_pkg::CH_PAD);
        has_data = kept && (pos_reg != 2'd0);
        pos_adv  = kept ? pos_reg + 2'd1 : pos_reg;
        bad_adv  = bad_reg | (kept & ~sextet_ok);

        unique case (pos_reg)
            2'd1:    data_byte = {prior_reg, sextet[5:4]};
            2'd2:    data_byte = {prior_reg[3:0], sextet[5:2]};
            2'd3:    data_byte = {prior_reg[1:0], sextet};
            default: data_byte = 8'h00;
        endcase

        if (pos_adv == 2'd1)
            end_kind = b64d_pkg::KIND_BAD_LENGTH;
        else if (bad_adv)
            end_kind = b64d_pkg::KIND_BAD_CHAR;
        else
            end_kind = b64d_pkg::KIND_OK;

        data_item = '{out_byte: data_byte, kind: b64d_pkg::KIND_DATA, eom: 1'b0};
        end_item  = '{out_byte: 8'h00, kind: end_kind, eom: 1'b1};

        push_n = {1'b0, has_data} + {1'b0, in_last_reg};
        // held character moves on only if the queue has room for all its results
        fire   = in_valid_reg && (CW'(push_n) <= fifo_free);

        push.count  = fire ? push_n : 2'd0;
        push.first  = has_data ? data_item : end_item;
        push.second = end_item;

        s_axis_tready = !in_valid_reg || fire;
        in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

        pos_next   = pos_reg;
        prior_next = prior_reg;
        bad_next   = bad_reg;
        if (fire)
        begin
            if (in_last_reg)
            begin
                pos_next   = 2'd0;
                prior_next = 6'd0;
                bad_next   = 1'b0;
            end
            else
            begin
                pos_next   = pos_adv;
                prior_next = kept ? sextet : prior_reg;
                bad_next   = bad_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= 2'd0;
            prior_reg    <= 6'd0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
            prior_reg    <= prior_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

endmodule

`default_nettype wire

>>> src/b64d_out_fifo.sv
`default_nettype none

// Result queue: up to two writes and one read per cycle.
module b64d_out_fifo #(
    parameter  int DEPTH = b64d_pkg::FIFO_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int PW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire b64d_pkg::push_t push,
    output logic [CW-1:0]        fifo_free,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [7:0]           m_axis_tdata,
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    b64d_pkg::result_t entry_reg [DEPTH];

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] tail_inc;
    logic          pop;
    b64d_pkg::result_t head_item;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        tail_inc  = ptr_inc(tail_reg);
        pop       = (count_reg != '0) && m_axis_tready;
        head_next = pop ? ptr_inc(head_reg) : head_reg;
        case (push.count)
            2'd1:    tail_next = tail_inc;
            2'd2:    tail_next = ptr_inc(tail_inc);
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CW'(push.count) - CW'(pop);
        fifo_free  = CW'(DEPTH) - count_reg;

        head_item     = entry_reg[head_reg];
        m_axis_tvalid = (count_reg != '0);
        m_axis_tdata  = head_item.out_byte;
        m_axis_tuser  = head_item.kind;
        m_axis_tlast  = head_item.eom;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count == 2'd1 || push.count == 2'd2)
            entry_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[tail_inc] <= push.second;
    end

endmodule

`default_nettype wire

>>> src/forgiving_base64_decoder_unit.sv
// Channel   Dir  tdata                  tuser            tlast
// s_axis    in   [7:0] in_char          -                final_char
// m_axis    out  [7:0] out_byte         [1:0] item_kind  end_of_message
//
// Steady flow takes one character per cycle while the result queue has room. A
// character is held in the input register and then written into the queue, whose
// head drives m_axis; a final character completing a byte queues two results.
// Reset (rst_n low, asynchronous) clears group state, flags and the queue.
// s_axis_tready drops only when the queue cannot hold all results of the held
// character; a stalled m_axis side fills the queue and then stalls input.
`default_nettype none

module forgiving_base64_decoder_unit #(
    // result queue depth, at least 2
    parameter int DEPTH = b64d_pkg::FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] in_char
    input  wire logic       s_axis_tlast,  // final_char

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,  // [1:0] item_kind
    output logic            m_axis_tlast   // end_of_message
);

    localparam int CW = $clog2(DEPTH + 1);

    // free slots in the result queue, registered count based
    logic [CW-1:0]   fifo_free;
    b64d_pkg::push_t push;

    // '-' and '_' map onto '+' and '/', '=' is dropped, other
    // characters outside the alphabet decode as zero and flag the message
    b64d_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .fifo_free     (fifo_free),
        .push          (push)
    );

    // queue decouples the two sides; head entry drives m_axis directly
    b64d_out_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .fifo_free     (fifo_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`include "forgiving_base64_decoder_unit_assert.svh"

    // end items carry a status and a zero byte
    `B64D_ASSERT_NOW(a_end_item_form, m_axis_tvalid && m_axis_tlast, (m_axis_tdata == 8'h00) && (m_axis_tuser != b64d_pkg::KIND_DATA), "end item with data byte or data kind")
    // data items never carry a status
    `B64D_ASSERT_NOW(a_data_item_form, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == b64d_pkg::KIND_DATA, "data item with status kind")
    // empty queue offers nothing
    `B64D_ASSERT_NOW(a_empty_no_valid, fifo_free == CW'(DEPTH), !m_axis_tvalid, "valid result from empty queue")
    // queue never reports more free slots than its depth
    `B64D_ASSERT_NEXT(a_free_bound, 1'b1, fifo_free <= CW'(DEPTH), "result queue overflow")

endmodule

`default_nettype wire
